FILE: sv/vectored_interrupt_manager_macros.svh
// Assertion macros of the interrupt manager verification, used by vim_checker.
// No dependencies.
`ifndef VECTORED_INTERRUPT_MANAGER_MACROS_SVH
`define VECTORED_INTERRUPT_MANAGER_MACROS_SVH

// same-cycle implication
`define VIM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VIM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/vim_pkg.sv
// Types, codes and constants of the vectored interrupt manager.
// No dependencies.
package vim_pkg;

    localparam int C_DATA_W         = 32;
    localparam int C_OFF_W          = 8;
    localparam int C_LINE_W         = 6;
    localparam int C_IDX_W          = 7;
    localparam int C_ENTRY_W        = 7;
    localparam int C_ENTRIES_PER_ROW = 4;
    localparam int C_ROW_W          = C_ENTRY_W * C_ENTRIES_PER_ROW;

    localparam logic [31:0] C_VT_BASE_RST = 32'hFFF8_2000;
    localparam logic [31:0] C_MAP_MASK    = 32'h7F7F_7F7F;
    localparam logic [31:0] C_FORCED_FAST = 32'h0000_0003;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_LINE  = 2'd2;

    localparam logic [7:0] OFF_IRQ_IDX = 8'h00;
    localparam logic [7:0] OFF_FIQ_IDX = 8'h04;
    localparam logic [7:0] OFF_IRQ_VEC = 8'h70;
    localparam logic [7:0] OFF_FIQ_VEC = 8'h74;

    localparam logic [3:0] GRP_FIQ_SEL = 4'h1;
    localparam logic [3:0] GRP_PEND    = 4'h2;
    localparam logic [3:0] GRP_EN_SET  = 4'h3;
    localparam logic [3:0] GRP_EN_CLR  = 4'h4;
    localparam logic [3:0] GRP_WK_SET  = 4'h5;
    localparam logic [3:0] GRP_WK_CLR  = 4'h6;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_MAPRD,
        ST_SCAN,
        ST_SCANEND,
        ST_PRIO,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic       found;
        logic [4:0] idx;
    } t_lsb;

    function automatic t_lsb f_lowest(input logic [31:0] a);
        t_lsb r;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            if (a[i]) begin
                r.found = 1'b1;
                r.idx   = 5'(i);
            end
        end
        return r;
    endfunction

    // implemented channel bits of a bank holding n channels
    function automatic logic [31:0] f_valid_word(input int n);
        logic [31:0] r;
        if (n >= 32) begin
            r = '1;
        end else if (n <= 0) begin
            r = '0;
        end else begin
            r = (32'd1 << n) - 32'd1;
        end
        return r;
    endfunction

endpackage

FILE: sv/vim_if.sv
// Handshake interfaces of the interrupt manager: item input, result output, config write.
// Depends on vim_pkg.
interface vim_in_if;
    import vim_pkg::*;
    logic                valid;
    logic                ready;
    logic [1:0]          mode;
    logic [C_OFF_W-1:0]  offset;
    logic [C_DATA_W-1:0] write_data;
    logic [C_LINE_W-1:0] line;
    logic                level;
    modport source (output valid, mode, offset, write_data, line, level, input ready);
    modport sink   (input valid, mode, offset, write_data, line, level, output ready);
endinterface

interface vim_out_if;
    import vim_pkg::*;
    logic                valid;
    logic                ready;
    logic [C_DATA_W-1:0] read_data;
    logic                access_error;
    logic                irq_out;
    logic                fiq_out;
    logic [C_IDX_W-1:0]  irq_number;
    logic [C_IDX_W-1:0]  fiq_number;
    modport source (output valid, read_data, access_error, irq_out, fiq_out, irq_number,
                    fiq_number, input ready);
    modport sink   (input valid, read_data, access_error, irq_out, fiq_out, irq_number,
                    fiq_number, output ready);
endinterface

interface vim_cfg_if;
    import vim_pkg::*;
    logic                valid;
    logic                ready;
    logic [C_DATA_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: sv/vim_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module vim_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 24
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                       i_wdata,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: sv/vectored_interrupt_manager.sv
// Vectored interrupt manager: one bus access or request line event per transaction,
// one result per transaction. After reset the channel map RAM is initialized one row
// (four channels) per cycle, while no transaction is taken. A register access goes
// through ST_EXEC, ST_PRIO and ST_DONE, a channel map read adds ST_MAPRD, and a line
// event adds ST_SCAN over the MW = ceil(NUM_CHANNELS/4) map rows and ST_SCANEND; a new
// transaction is taken only after the last one has left ST_DONE. The line event
// scans the map RAM one row per cycle through one 4-entry compare unit, and every
// transaction ends with a bank-by-bank lowest-channel search for both classes.
// Depends on vim_pkg, vim_if, vim_ram.
module vectored_interrupt_manager #(
    parameter int NUM_CHANNELS = 96,
    parameter int NUM_LINES    = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vim_in_if.sink     i_in,
    vim_cfg_if.sink    i_cfg,
    vim_out_if.source  o_out
);
    import vim_pkg::*;

    localparam int NB = (NUM_CHANNELS + 31) / 32;
    localparam int MW = (NUM_CHANNELS + 3) / 4;
    localparam int AW = (MW > 1) ? $clog2(MW) : 1;
    localparam int BW = (NB > 1) ? $clog2(NB) : 1;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_row, n_row;
    logic [BW-1:0]     r_bank, n_bank;
    logic              r_scan_vld, n_scan_vld;
    logic [AW-1:0]     r_scan_row, n_scan_row;
    logic [1:0]        r_mode, n_mode;
    logic [7:0]        r_off, n_off;
    logic [31:0]       r_wdata, n_wdata;
    logic [5:0]        r_line, n_line;
    logic              r_level, n_level;
    logic [31:0]       r_rdata, n_rdata;
    logic              r_err, n_err;
    logic              r_rd_bank, n_rd_bank;
    logic [31:0]       r_fiq_sel [NB];
    logic [31:0]       n_fiq_sel [NB];
    logic [31:0]       r_pend [NB];
    logic [31:0]       n_pend [NB];
    logic [31:0]       r_en [NB];
    logic [31:0]       n_en [NB];
    logic [31:0]       r_wake [NB];
    logic [31:0]       n_wake [NB];
    logic [6:0]        r_irq_idx, n_irq_idx;
    logic [6:0]        r_fiq_idx, n_fiq_idx;
    logic [6:0]        r_irq_new, n_irq_new;
    logic [6:0]        r_fiq_new, n_fiq_new;
    logic [31:0]       r_vt_base, n_vt_base;
    logic              r_o_vld, n_o_vld;
    logic [31:0]       r_o_rdata, n_o_rdata;
    logic              r_o_err, n_o_err;
    logic [6:0]        r_o_irq, n_o_irq;
    logic [6:0]        r_o_fiq, n_o_fiq;

    logic              in_ready;
    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [C_ROW_W-1:0] ram_wdata, ram_rdata;
    logic [C_ROW_W-1:0] init_row, map_wr_row;
    logic [31:0]       map_rd_word;
    logic              aligned, is_map, map_ok, bank_ok;
    logic [BW-1:0]     bsel;
    logic [3:0]        grp;
    logic [31:0]       force_w, vmask;
    logic [31:0]       act_f, act_i;
    t_lsb              lsb_f, lsb_i;

    vim_ram #(
        .WIDTH (C_ROW_W),
        .DEPTH (MW)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        aligned = (r_off[1:0] == 2'b00);
        is_map  = r_off[7];
        map_ok  = int'(r_off[6:2]) < MW;
        bank_ok = int'(r_off[3:2]) < NB;
        bsel    = BW'(r_off[3:2]);
        grp     = r_off[7:4];
        force_w = (r_off[3:2] == 2'd0) ? C_FORCED_FAST : 32'd0;
        vmask   = f_valid_word(NUM_CHANNELS - int'(r_off[3:2]) * 32);
        act_f   = r_pend[r_bank] & r_en[r_bank] & r_fiq_sel[r_bank];
        act_i   = r_pend[r_bank] & r_en[r_bank] & ~r_fiq_sel[r_bank];
        lsb_f   = f_lowest(act_f);
        lsb_i   = f_lowest(act_i);
    end

    always_comb begin
        map_rd_word = '0;
        for (int k = 0; k < C_ENTRIES_PER_ROW; k++) begin
            init_row[C_ENTRY_W*(3-k) +: C_ENTRY_W] = 7'(int'(r_row) * 4 + k);
            map_wr_row[C_ENTRY_W*(3-k) +: C_ENTRY_W] = r_wdata[(24 - 8*k) +: C_ENTRY_W];
            if (int'(r_off[6:2]) * 4 + k < NUM_CHANNELS) begin
                map_rd_word[(24 - 8*k) +: C_ENTRY_W] = ram_rdata[C_ENTRY_W*(3-k) +: C_ENTRY_W];
            end
        end
    end

    always_comb begin
        int ch;
        n_state    = r_state;
        n_row      = r_row;
        n_bank     = r_bank;
        n_scan_vld = 1'b0;
        n_scan_row = r_scan_row;
        n_mode     = r_mode;
        n_off      = r_off;
        n_wdata    = r_wdata;
        n_line     = r_line;
        n_level    = r_level;
        n_rdata    = r_rdata;
        n_err      = r_err;
        n_rd_bank  = r_rd_bank;
        n_fiq_sel  = r_fiq_sel;
        n_pend     = r_pend;
        n_en       = r_en;
        n_wake     = r_wake;
        n_irq_idx  = r_irq_idx;
        n_fiq_idx  = r_fiq_idx;
        n_irq_new  = r_irq_new;
        n_fiq_new  = r_fiq_new;
        n_vt_base  = r_vt_base;
        n_o_vld    = r_o_vld;
        n_o_rdata  = r_o_rdata;
        n_o_err    = r_o_err;
        n_o_irq    = r_o_irq;
        n_o_fiq    = r_o_fiq;
        in_ready   = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = r_row;
        ram_wdata  = init_row;
        ch         = 0;

        if (i_cfg.valid) begin
            n_vt_base = i_cfg.data;
        end
        if (r_o_vld && o_out.ready) begin
            n_o_vld = 1'b0;
        end

        // map row read in the previous cycle is compared against the line
        if (r_scan_vld) begin
            for (int k = 0; k < C_ENTRIES_PER_ROW; k++) begin
                ch = int'(r_scan_row) * 4 + k;
                if (ch < NUM_CHANNELS &&
                    ram_rdata[C_ENTRY_W*(3-k) +: C_ENTRY_W] == {1'b0, r_line}) begin
                    n_pend[BW'(ch >> 5)][5'(ch)] = r_level;
                end
            end
        end

        case (r_state)
            ST_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = init_row;
                n_row     = r_row + AW'(1);
                if (r_row == AW'(MW - 1)) begin
                    n_row   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (i_in.valid) begin
                    n_mode  = i_in.mode;
                    n_off   = i_in.offset;
                    n_wdata = i_in.write_data;
                    n_line  = i_in.line;
                    n_level = i_in.level;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_rdata   = '0;
                n_err     = 1'b0;
                n_rd_bank = 1'b0;
                n_bank    = '0;
                n_irq_new = '0;
                n_fiq_new = '0;
                n_row     = '0;
                n_state   = ST_PRIO;
                ram_addr  = AW'(r_off[6:2]);
                ram_wdata = map_wr_row;
                case (r_mode)
                    MODE_READ: begin
                        if (!aligned) begin
                            n_err = 1'b1;
                        end else if (r_off == OFF_IRQ_IDX) begin
                            n_rdata = 32'(r_irq_idx);
                        end else if (r_off == OFF_FIQ_IDX) begin
                            n_rdata = 32'(r_fiq_idx);
                        end else if (r_off == OFF_IRQ_VEC) begin
                            n_rdata = r_vt_base + {23'd0, r_irq_idx, 2'b00};
                        end else if (r_off == OFF_FIQ_VEC) begin
                            n_rdata = r_vt_base + {23'd0, r_fiq_idx, 2'b00};
                        end else if (is_map) begin
                            if (map_ok) begin
                                n_state = ST_MAPRD;
                            end else begin
                                n_err = 1'b1;
                            end
                        end else if (!bank_ok) begin
                            n_err = 1'b1;
                        end else begin
                            case (grp)
                                GRP_FIQ_SEL, GRP_PEND, GRP_EN_SET,
                                GRP_EN_CLR, GRP_WK_SET, GRP_WK_CLR: begin
                                    n_rd_bank = 1'b1;
                                end
                                default: begin
                                    n_err = 1'b1;
                                end
                            endcase
                        end
                    end
                    MODE_WRITE: begin
                        if (!aligned) begin
                            n_err = 1'b1;
                        end else if (r_off == OFF_IRQ_IDX || r_off == OFF_FIQ_IDX ||
                                     r_off == OFF_IRQ_VEC || r_off == OFF_FIQ_VEC) begin
                            n_err = 1'b0;
                        end else if (is_map) begin
                            if (map_ok) begin
                                ram_we = 1'b1;
                            end else begin
                                n_err = 1'b1;
                            end
                        end else if (!bank_ok) begin
                            n_err = 1'b1;
                        end else begin
                            case (grp)
                                GRP_FIQ_SEL: n_fiq_sel[bsel] = (r_wdata | force_w) & vmask;
                                GRP_PEND:    n_err = 1'b0;
                                GRP_EN_SET:  n_en[bsel] = r_en[bsel] |
                                                          ((r_wdata | force_w) & vmask);
                                GRP_EN_CLR:  n_en[bsel] = r_en[bsel] & (~r_wdata | force_w);
                                GRP_WK_SET:  n_wake[bsel] = r_wake[bsel] | (r_wdata & vmask);
                                GRP_WK_CLR:  n_wake[bsel] = r_wake[bsel] & ~r_wdata;
                                default:     n_err = 1'b1;
                            endcase
                        end
                    end
                    MODE_LINE: begin
                        if (int'(r_line) < NUM_LINES) begin
                            n_state = ST_SCAN;
                        end
                    end
                    default: begin
                        n_err = 1'b1;
                    end
                endcase
            end
            ST_MAPRD: begin
                n_rdata = map_rd_word;
                n_state = ST_PRIO;
            end
            ST_SCAN: begin
                ram_addr   = r_row;
                n_scan_vld = 1'b1;
                n_scan_row = r_row;
                n_row      = r_row + AW'(1);
                if (r_row == AW'(MW - 1)) begin
                    n_row   = '0;
                    n_state = ST_SCANEND;
                end
            end
            ST_SCANEND: begin
                n_state = ST_PRIO;
            end
            ST_PRIO: begin
                if (lsb_f.found && r_fiq_new == '0) begin
                    n_fiq_new = 7'({r_bank, lsb_f.idx}) + 7'd1;
                end
                if (lsb_i.found && r_irq_new == '0) begin
                    n_irq_new = 7'({r_bank, lsb_i.idx}) + 7'd1;
                end
                if (r_rd_bank && int'(r_bank) == int'(r_off[3:2])) begin
                    case (grp)
                        GRP_FIQ_SEL:            n_rdata = r_fiq_sel[r_bank];
                        GRP_PEND:               n_rdata = r_pend[r_bank];
                        GRP_EN_SET, GRP_EN_CLR: n_rdata = r_en[r_bank];
                        GRP_WK_SET, GRP_WK_CLR: n_rdata = r_wake[r_bank];
                        default:                n_rdata = r_rdata;
                    endcase
                end
                if (r_bank == BW'(NB - 1)) begin
                    n_irq_idx = n_irq_new;
                    n_fiq_idx = n_fiq_new;
                    n_state   = ST_DONE;
                end else begin
                    n_bank = r_bank + BW'(1);
                end
            end
            ST_DONE: begin
                if (!r_o_vld || o_out.ready) begin
                    n_o_vld   = 1'b1;
                    n_o_rdata = r_rdata;
                    n_o_err   = r_err;
                    n_o_irq   = r_irq_idx;
                    n_o_fiq   = r_fiq_idx;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_INIT;
            r_row      <= '0;
            r_bank     <= '0;
            r_scan_vld <= 1'b0;
            r_rd_bank  <= 1'b0;
            r_irq_idx  <= '0;
            r_fiq_idx  <= '0;
            r_vt_base  <= C_VT_BASE_RST;
            r_o_vld    <= 1'b0;
            for (int b = 0; b < NB; b++) begin
                r_fiq_sel[b] <= (b == 0) ? C_FORCED_FAST : 32'd0;
                r_pend[b]    <= '0;
                r_en[b]      <= '0;
                r_wake[b]    <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_row      <= n_row;
            r_bank     <= n_bank;
            r_scan_vld <= n_scan_vld;
            r_rd_bank  <= n_rd_bank;
            r_irq_idx  <= n_irq_idx;
            r_fiq_idx  <= n_fiq_idx;
            r_vt_base  <= n_vt_base;
            r_o_vld    <= n_o_vld;
            r_fiq_sel  <= n_fiq_sel;
            r_pend     <= n_pend;
            r_en       <= n_en;
            r_wake     <= n_wake;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_row <= n_scan_row;
        r_mode     <= n_mode;
        r_off      <= n_off;
        r_wdata    <= n_wdata;
        r_line     <= n_line;
        r_level    <= n_level;
        r_rdata    <= n_rdata;
        r_err      <= n_err;
        r_irq_new  <= n_irq_new;
        r_fiq_new  <= n_fiq_new;
        r_o_rdata  <= n_o_rdata;
        r_o_err    <= n_o_err;
        r_o_irq    <= n_o_irq;
        r_o_fiq    <= n_o_fiq;
    end

    assign i_in.ready         = in_ready;
    assign i_cfg.ready        = 1'b1;
    assign o_out.valid        = r_o_vld;
    assign o_out.read_data    = r_o_rdata;
    assign o_out.access_error = r_o_err;
    assign o_out.irq_number   = r_o_irq;
    assign o_out.fiq_number   = r_o_fiq;
    assign o_out.irq_out      = (r_o_irq != '0);
    assign o_out.fiq_out      = (r_o_fiq != '0);
endmodule

FILE: sv/vim_checker.sv
// Port-level checks of the interrupt manager result channel, bound to the top level.
// Depends on vectored_interrupt_manager_macros.svh and vectored_interrupt_manager.
`include "vectored_interrupt_manager_macros.svh"

module vim_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [31:0] i_read_data,
    input logic       i_irq_out,
    input logic       i_fiq_out,
    input logic [6:0] i_irq_number,
    input logic [6:0] i_fiq_number
);
    `VIM_ASSERT_SAME(a_irq_line, i_clk, i_rst_n, i_out_valid, i_irq_out == (i_irq_number != 7'd0), "irq_out disagrees with irq_number")
    `VIM_ASSERT_SAME(a_fiq_line, i_clk, i_rst_n, i_out_valid, i_fiq_out == (i_fiq_number != 7'd0), "fiq_out disagrees with fiq_number")
    `VIM_ASSERT_SAME(a_class_excl, i_clk, i_rst_n, i_out_valid && (i_irq_number != 7'd0), i_irq_number != i_fiq_number, "channel reported in both classes")
    `VIM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_read_data) && $stable(i_irq_number), "stalled result changed")
endmodule

bind vectored_interrupt_manager vim_checker u_vim_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_read_data  (o_out.read_data),
    .i_irq_out    (o_out.irq_out),
    .i_fiq_out    (o_out.fiq_out),
    .i_irq_number (o_out.irq_number),
    .i_fiq_number (o_out.fiq_number)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of vectored_interrupt_manager: directed and random bus
// accesses and line events, predicted per transaction and checked in order.
// Depends on vim_pkg, vim_if and the RTL of the block.
module tb_top;
    import vim_pkg::*;

    localparam int NUM_CH  = 96;
    localparam int NUM_LN  = 64;
    localparam int NB      = (NUM_CH + 31) / 32;
    localparam int MW      = (NUM_CH + 3) / 4;
    localparam int SETTLE  = 40;
    localparam int LIMIT   = 400000;
    localparam int PER_PHASE = 165;
    localparam int PHASES  = 5;

    localparam logic [1:0] MODE_BAD = 2'd3;
    localparam logic [7:0] OFF_MAP  = 8'h80;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  off;
        logic [31:0] wdata;
        logic [5:0]  ln;
        logic        lvl;
    } req_t;

    typedef struct packed {
        logic [31:0] rdata;
        logic        err;
        logic        irq;
        logic        fiq;
        logic [6:0]  irq_n;
        logic [6:0]  fiq_n;
    } resp_t;

    logic i_clk;
    logic i_rst_n;

    vim_in_if  in_if ();
    vim_out_if out_if ();
    vim_cfg_if cfg_if ();

    vectored_interrupt_manager #(
        .NUM_CHANNELS(NUM_CH),
        .NUM_LINES   (NUM_LN)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .i_cfg  (cfg_if),
        .o_out  (out_if)
    );

    // interrupt controller state as seen by the predictor
    logic [31:0] vt_base;
    logic [31:0] fsel [NB];
    logic [31:0] pend [NB];
    logic [31:0] en   [NB];
    logic [31:0] wk   [NB];
    logic [6:0]  cmap [NUM_CH];
    logic [6:0]  irq_idx;
    logic [6:0]  fiq_idx;

    req_t  item_q [$];
    resp_t exp_q  [$];

    int  n_queued;
    int  n_acc;
    int  n_line;
    int  n_checked;
    int  errors;
    int  cycles;
    int  idle_pct;
    int  src_gap;
    int  snk_gap;
    bit  in_fire;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic logic [31:0] bank_mask(input int b);
        int n;
        n = NUM_CH - b * 32;
        if (n >= 32) return '1;
        if (n <= 0) return '0;
        return (32'd1 << n) - 32'd1;
    endfunction

    function automatic logic [7:0] bank_reg(input logic [3:0] grp, input int b);
        return {grp, 2'(b), 2'b00};
    endfunction

    function automatic logic [6:0] lowest_active(input bit fast);
        logic [31:0] act;
        for (int b = 0; b < NB; b++) begin
            act = pend[b] & en[b] & (fast ? fsel[b] : ~fsel[b]) & bank_mask(b);
            for (int j = 0; j < 32; j++) begin
                if (act[j]) return 7'(b * 32 + j + 1);
            end
        end
        return '0;
    endfunction

    function automatic bit reg_read(input logic [7:0] off, output logic [31:0] d);
        int b;
        int w;
        b = int'(off[3:2]);
        d = '0;
        if (off == OFF_IRQ_IDX) begin
            d = 32'(irq_idx);
            return 1'b1;
        end
        if (off == OFF_FIQ_IDX) begin
            d = 32'(fiq_idx);
            return 1'b1;
        end
        if (off == OFF_IRQ_VEC) begin
            d = vt_base + {23'd0, irq_idx, 2'b00};
            return 1'b1;
        end
        if (off == OFF_FIQ_VEC) begin
            d = vt_base + {23'd0, fiq_idx, 2'b00};
            return 1'b1;
        end
        if (off >= OFF_MAP) begin
            w = int'(off[6:2]);
            if (w >= MW) return 1'b0;
            for (int k = 0; k < 4; k++) begin
                if (w * 4 + k < NUM_CH) d |= 32'(cmap[w * 4 + k]) << (24 - 8 * k);
            end
            return 1'b1;
        end
        if (b >= NB) return 1'b0;
        case (off[7:4])
            GRP_FIQ_SEL: d = fsel[b];
            GRP_PEND: d = pend[b];
            GRP_EN_SET, GRP_EN_CLR: d = en[b];
            GRP_WK_SET, GRP_WK_CLR: d = wk[b];
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic bit reg_write(input logic [7:0] off, input logic [31:0] v);
        int b;
        int w;
        logic [31:0] frc;
        logic [31:0] m;
        b = int'(off[3:2]);
        frc = '0;
        if (off == OFF_IRQ_IDX || off == OFF_FIQ_IDX || off == OFF_IRQ_VEC
            || off == OFF_FIQ_VEC) return 1'b1;
        if (off >= OFF_MAP) begin
            w = int'(off[6:2]);
            if (w >= MW) return 1'b0;
            m = v & C_MAP_MASK;
            for (int k = 0; k < 4; k++) begin
                if (w * 4 + k < NUM_CH) cmap[w * 4 + k] = m[24 - 8 * k +: 7];
            end
            return 1'b1;
        end
        if (b >= NB) return 1'b0;
        if (b == 0) frc = C_FORCED_FAST;
        case (off[7:4])
            GRP_FIQ_SEL: fsel[b] = (v | frc) & bank_mask(b);
            GRP_PEND: begin end
            GRP_EN_SET: en[b] |= (v | frc) & bank_mask(b);
            GRP_EN_CLR: en[b] &= ~v | frc;
            GRP_WK_SET: wk[b] |= v & bank_mask(b);
            GRP_WK_CLR: wk[b] &= ~v;
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic resp_t predict_resp(input req_t q);
        resp_t r;
        logic [31:0] d;
        bit ok;
        r = '0;
        d = '0;
        ok = 1'b1;
        case (q.op)
            MODE_READ: begin
                if (q.off[1:0] != 2'b00) ok = 1'b0;
                else ok = reg_read(q.off, d);
                r.rdata = ok ? d : '0;
            end
            MODE_WRITE: begin
                if (q.off[1:0] != 2'b00) ok = 1'b0;
                else ok = reg_write(q.off, q.wdata);
            end
            MODE_LINE: begin
                if (int'(q.ln) < NUM_LN) begin
                    for (int ch = 0; ch < NUM_CH; ch++) begin
                        if (cmap[ch] == {1'b0, q.ln}) pend[ch / 32][ch % 32] = q.lvl;
                    end
                end
            end
            default: ok = 1'b0;
        endcase
        irq_idx = lowest_active(1'b0);
        fiq_idx = lowest_active(1'b1);
        r.err   = !ok;
        r.irq   = irq_idx != '0;
        r.fiq   = fiq_idx != '0;
        r.irq_n = irq_idx;
        r.fiq_n = fiq_idx;
        return r;
    endfunction

    function automatic req_t rand_req();
        req_t r;
        int pick;
        int k;
        r.op    = MODE_READ;
        r.off   = OFF_IRQ_IDX;
        r.wdata = $urandom;
        r.ln    = 6'($urandom);
        r.lvl   = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 36) begin
            r.op  = MODE_LINE;
            r.lvl = ($urandom_range(0, 9) < 6);
        end else if (pick < 52) begin
            r.op  = MODE_WRITE;
            r.off = bank_reg($urandom_range(0, 1) ? GRP_EN_SET : GRP_EN_CLR,
                             $urandom_range(0, NB - 1));
        end else if (pick < 60) begin
            r.op  = MODE_WRITE;
            r.off = bank_reg(GRP_FIQ_SEL, $urandom_range(0, NB - 1));
        end else if (pick < 66) begin
            r.op  = MODE_WRITE;
            r.off = bank_reg($urandom_range(0, 1) ? GRP_WK_SET : GRP_WK_CLR,
                             $urandom_range(0, NB - 1));
        end else if (pick < 74) begin
            r.op  = MODE_WRITE;
            r.off = OFF_MAP + 8'($urandom_range(0, MW - 1) * 4);
            for (k = 0; k < 4; k++) begin
                r.wdata[8 * k +: 8] = ($urandom_range(0, 9) < 8) ?
                    8'($urandom_range(0, NUM_LN - 1)) : 8'($urandom);
            end
        end else if (pick < 91) begin
            k = $urandom_range(0, 9);
            if (k == 0) r.off = OFF_IRQ_IDX;
            else if (k == 1) r.off = OFF_FIQ_IDX;
            else if (k == 2) r.off = OFF_IRQ_VEC;
            else if (k == 3) r.off = OFF_FIQ_VEC;
            else if (k == 4) r.off = OFF_MAP + 8'($urandom_range(0, MW - 1) * 4);
            else r.off = bank_reg(4'($urandom_range(1, 6)), $urandom_range(0, NB - 1));
        end else begin
            r.op  = 2'($urandom_range(0, 3));
            r.off = 8'($urandom);
        end
        return r;
    endfunction

    function automatic void queue_req(input req_t r);
        item_q.push_back(r);
        n_queued++;
    endfunction

    task automatic cmp_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want_v, got_v);
            errors++;
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        while (n_acc != n_queued || exp_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_base(input logic [31:0] v);
        cfg_if.data  <= v;
        cfg_if.valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // driver: source and sink sides, changed on the falling edge
    always @(negedge i_clk) begin : drv
        req_t q;
        if (!i_rst_n) begin
            in_if.valid  <= 1'b0;
            out_if.ready <= 1'b0;
        end else begin
            if (!in_if.valid || in_fire) begin
                if (src_gap > 0) begin
                    src_gap--;
                    in_if.valid <= 1'b0;
                end else if (item_q.size() > 0) begin
                    q = item_q.pop_front();
                    in_if.mode       <= q.op;
                    in_if.offset     <= q.off;
                    in_if.write_data <= q.wdata;
                    in_if.line       <= q.ln;
                    in_if.level      <= q.lvl;
                    in_if.valid      <= 1'b1;
                    if ($urandom_range(0, 99) < idle_pct) src_gap = $urandom_range(1, 13);
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
            if (snk_gap > 0) begin
                snk_gap--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                if ($urandom_range(0, 199) < idle_pct) snk_gap = $urandom_range(1, 13);
            end
        end
    end

    // monitor: accepted transactions on all three channels, sampled on the rising edge
    always @(posedge i_clk) begin : mon
        req_t  q;
        resp_t got;
        resp_t want;
        cycles++;
        in_fire = 1'b0;
        if (cycles > LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else if (!i_rst_n) begin
            vt_base = C_VT_BASE_RST;
            for (int b = 0; b < NB; b++) begin
                fsel[b] = '0;
                pend[b] = '0;
                en[b]   = '0;
                wk[b]   = '0;
            end
            fsel[0] = C_FORCED_FAST;
            for (int k = 0; k < NUM_CH; k++) cmap[k] = 7'(k);
            irq_idx = '0;
            fiq_idx = '0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                got = '{out_if.read_data, out_if.access_error, out_if.irq_out,
                        out_if.fiq_out, out_if.irq_number, out_if.fiq_number};
                if (exp_q.size() == 0) begin
                    $display("%0t: result with none expected, expected none actual %h",
                             $time, got);
                    errors++;
                end else begin
                    want = exp_q.pop_front();
                    cmp_field("read_data", want.rdata, got.rdata);
                    cmp_field("access_error", 32'(want.err), 32'(got.err));
                    cmp_field("irq_out", 32'(want.irq), 32'(got.irq));
                    cmp_field("fiq_out", 32'(want.fiq), 32'(got.fiq));
                    cmp_field("irq_number", 32'(want.irq_n), 32'(got.irq_n));
                    cmp_field("fiq_number", 32'(want.fiq_n), 32'(got.fiq_n));
                    n_checked++;
                end
            end
            if (cfg_if.valid && cfg_if.ready) vt_base = cfg_if.data;
            if (in_if.valid && in_if.ready) begin
                in_fire = 1'b1;
                q = '{in_if.mode, in_if.offset, in_if.write_data, in_if.line, in_if.level};
                exp_q.push_back(predict_resp(q));
                n_acc++;
                if (q.op == MODE_LINE) n_line++;
            end
        end
    end

    initial begin
        in_if.valid      = 1'b0;
        in_if.mode       = MODE_READ;
        in_if.offset     = '0;
        in_if.write_data = '0;
        in_if.line       = '0;
        in_if.level      = 1'b0;
        out_if.ready     = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.data      = '0;
        i_rst_n          = 1'b0;
        idle_pct         = 20;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset values, forced fast channels, map edge cases, bad accesses
        queue_req('{MODE_READ,  OFF_IRQ_IDX, 32'h0, 6'd0, 1'b0});
        queue_req('{MODE_READ,  OFF_FIQ_VEC, 32'h0, 6'd0, 1'b0});
        queue_req('{MODE_WRITE, bank_reg(GRP_FIQ_SEL, 0), 32'h0, 6'd0, 1'b0});
        queue_req('{MODE_READ,  bank_reg(GRP_FIQ_SEL, 0), 32'h0, 6'd0, 1'b0});
        queue_req('{MODE_WRITE, bank_reg(GRP_EN_SET, 0), 32'hFFFF_FFFF, 6'd0, 1'b0});
        queue_req('{MODE_WRITE, bank_reg(GRP_EN_SET, NB - 1), 32'hFFFF_FFFF, 6'd0, 1'b0});
        queue_req('{MODE_LINE,  8'h00, 32'h0, 6'd5, 1'b1});
        queue_req('{MODE_LINE,  8'h00, 32'h0, 6'd0, 1'b1});
        queue_req('{MODE_READ,  OFF_IRQ_VEC, 32'h0, 6'd0, 1'b0});
        queue_req('{MODE_WRITE, bank_reg(GRP_EN_CLR, 0), 32'hFFFF_FFFF, 6'd0, 1'b0});
        queue_req('{MODE_WRITE, OFF_MAP + 8'h40, 32'h3F3F_3F3F, 6'd0, 1'b0});
        queue_req('{MODE_LINE,  8'h00, 32'h0, 6'd63, 1'b1});
        queue_req('{MODE_LINE,  8'h00, 32'h0, 6'd0, 1'b0});
        queue_req('{MODE_WRITE, OFF_MAP, 32'hFFFF_FFFF, 6'd0, 1'b0});
        queue_req('{MODE_READ,  OFF_MAP, 32'h0, 6'd0, 1'b0});
        queue_req('{MODE_READ,  OFF_MAP + 8'h5C, 32'h0, 6'd0, 1'b0});
        queue_req('{MODE_READ,  8'h01, 32'h0, 6'd0, 1'b0});
        queue_req('{MODE_WRITE, 8'h03, 32'h1234_5678, 6'd0, 1'b0});
        queue_req('{MODE_READ,  8'h78, 32'h0, 6'd0, 1'b0});
        queue_req('{MODE_WRITE, 8'hFC, 32'hFFFF_FFFF, 6'd0, 1'b0});
        queue_req('{MODE_WRITE, OFF_IRQ_IDX, 32'hFFFF_FFFF, 6'd0, 1'b0});
        queue_req('{MODE_BAD,   8'hFF, 32'hFFFF_FFFF, 6'd63, 1'b1});
        queue_req('{MODE_WRITE, bank_reg(GRP_WK_SET, NB - 1), 32'hFFFF_FFFF, 6'd0, 1'b0});
        queue_req('{MODE_WRITE, bank_reg(GRP_WK_CLR, NB - 1), 32'h0000_FFFF, 6'd0, 1'b0});
        queue_req('{MODE_READ,  8'h1C, 32'h0, 6'd0, 1'b0});
        queue_req('{MODE_READ,  bank_reg(GRP_PEND, NB - 1), 32'h0, 6'd0, 1'b0});

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                drain();
                case (ph)
                    1: write_base(32'h0000_0000);
                    2: write_base(32'hFFFF_FFFF);
                    3: write_base($urandom);
                    default: write_base(32'h8000_0000);
                endcase
            end
            idle_pct = (ph == PHASES - 1) ? 0 : (ph == 2 ? 6 : 25);
            for (int i = 0; i < PER_PHASE; i++) queue_req(rand_req());
        end
        drain();

        $display("Covered %0d transactions (%0d line events) over %0d vector base settings,",
                 n_acc, n_line, PHASES);
        $display("%0d results checked, %0d mismatches", n_checked, errors);
        if (errors == 0 && exp_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/vim_pkg.sv
sv/vim_if.sv
sv/vim_ram.sv
sv/vectored_interrupt_manager.sv
sv/vim_checker.sv
tb/sv/tb_top.sv
